[hdl/rds_pkg.sv]
// Shared constants and helper functions for the reverse docking steering block.
package rds_pkg;

  localparam int unsigned XW    = 16;
  localparam int unsigned MODEW = 3;
  localparam int unsigned ZONEW = 2;
  localparam int unsigned LINW  = 11;
  localparam int unsigned TURNW = 13;
  localparam int unsigned STW   = 2;
  localparam int unsigned CIDXW = 3;
  localparam int unsigned CDATW = 14;

  localparam logic [CIDXW-1:0] CfgSpeedMin = 3'd0;
  localparam logic [CIDXW-1:0] CfgSpeedMax = 3'd1;
  localparam logic [CIDXW-1:0] CfgTurnCap  = 3'd2;
  localparam logic [CIDXW-1:0] CfgSlowZone = 3'd3;
  localparam logic [CIDXW-1:0] CfgLookAhd  = 3'd4;
  localparam logic [CIDXW-1:0] CfgArrivTol = 3'd5;

  localparam logic [STW-1:0] StatRun     = 2'd0;
  localparam logic [STW-1:0] StatArrived = 2'd1;
  localparam logic [STW-1:0] StatPoseErr = 2'd2;

  localparam logic [1:0] WarnNone     = 2'd0;
  localparam logic [1:0] WarnObstacle = 2'd1;
  localparam logic [1:0] WarnPoseErr  = 2'd2;

  localparam logic [MODEW-1:0] ModeReset = 3'd0;
  localparam logic [MODEW-1:0] ModeRun1  = 3'd1;
  localparam logic [MODEW-1:0] ModeRun3  = 3'd3;

  localparam logic [1:0] DirNone  = 2'd0;
  localparam logic [1:0] DirLeft  = 2'd1;
  localparam logic [1:0] DirRight = 2'd2;

  localparam int PiQ13     = 25736;
  localparam int HalfPiQ13 = 12868;
  localparam int TurnLimit = 4000;
  localparam int SpeedLim  = 1000;
  localparam int KNear     = 250;
  localparam int KHead     = 55000;
  localparam int KLat      = 368640;
  localparam int FarBias   = 409600;
  // ceil(2^25 / 25): exact floor divide by 25 for dividends below 2^20
  localparam int FarRecip  = 1342178;
  localparam int SqrtSteps = 24;
  localparam int CordSteps = 17;

  // arctan(2^-i) in Q16
  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0:    atan_q16 = 17'd51472;
      5'd1:    atan_q16 = 17'd30385;
      5'd2:    atan_q16 = 17'd16055;
      5'd3:    atan_q16 = 17'd8150;
      5'd4:    atan_q16 = 17'd4091;
      5'd5:    atan_q16 = 17'd2047;
      5'd6:    atan_q16 = 17'd1024;
      5'd7:    atan_q16 = 17'd512;
      5'd8:    atan_q16 = 17'd256;
      5'd9:    atan_q16 = 17'd128;
      5'd10:   atan_q16 = 17'd64;
      5'd11:   atan_q16 = 17'd32;
      5'd12:   atan_q16 = 17'd16;
      5'd13:   atan_q16 = 17'd8;
      5'd14:   atan_q16 = 17'd4;
      5'd15:   atan_q16 = 17'd2;
      5'd16:   atan_q16 = 17'd1;
      default: atan_q16 = 17'd0;
    endcase
  endfunction

  // saturate a wide turn rate to the output range
  function automatic logic signed [TURNW-1:0] sat_turn(input logic signed [25:0] t);
    if (t > 26'sd4000) sat_turn = 13'sd4000;
    else if (t < -26'sd4000) sat_turn = -13'sd4000;
    else sat_turn = t[TURNW-1:0];
  endfunction

endpackage

[hdl/reverse_docking_steer.sv]
// Reverse docking steering: speed and turn rate from pose relative to a docking target.
// Each word is worked on alone by one sequencer around a shared multiplier, a
// bit-serial square root (24 steps), a restoring divider (24 steps) for the
// slow-zone speed scaling and a 17-step CORDIC; in_stall_o is high from
// acceptance until the result is loaded into the output register. A word that
// fails the pose check, has arrived, is blocked by an obstacle or whose mode
// does not run goes from the first square root straight to the output; in the
// near field the near turn step follows, inside the slow zone a second square root
// and the divide come first, and in the far field the CORDIC runs. A new word
// is taken while the previous result still waits on out_stall_i.
module reverse_docking_steer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rds_pkg::CIDXW-1:0]           cfg_idx_i,
  input  logic [rds_pkg::CDATW-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [rds_pkg::XW-1:0]       offset_x_i,
  input  logic signed [rds_pkg::XW-1:0]       offset_y_i,
  input  logic signed [rds_pkg::XW-1:0]       heading_i,
  input  logic                                pose_ok_i,
  input  logic [rds_pkg::MODEW-1:0]           run_mode_i,
  input  logic [rds_pkg::ZONEW-1:0]           rear_zone_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [rds_pkg::LINW-1:0]     linear_speed_o,
  output logic signed [rds_pkg::TURNW-1:0]    turn_rate_o,
  output logic [rds_pkg::STW-1:0]             step_status_o,
  output logic [1:0]                          warning_o
);
  import rds_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MXX  = 5'd1;
  localparam logic [4:0] S_MYY  = 5'd2;
  localparam logic [4:0] S_MSS  = 5'd3;
  localparam logic [4:0] S_SQI  = 5'd4;
  localparam logic [4:0] S_SQRT = 5'd5;
  localparam logic [4:0] S_CHK  = 5'd6;
  localparam logic [4:0] S_MV   = 5'd7;
  localparam logic [4:0] S_SQI2 = 5'd8;
  localparam logic [4:0] S_DIVI = 5'd9;
  localparam logic [4:0] S_DIV  = 5'd10;
  localparam logic [4:0] S_VEL  = 5'd11;
  localparam logic [4:0] S_TURN = 5'd12;
  localparam logic [4:0] S_NFIN = 5'd13;
  localparam logic [4:0] S_CORI = 5'd14;
  localparam logic [4:0] S_COR  = 5'd15;
  localparam logic [4:0] S_CORF = 5'd16;
  localparam logic [4:0] S_FE   = 5'd17;
  localparam logic [4:0] S_FM2  = 5'd18;
  localparam logic [4:0] S_FM3  = 5'd19;
  localparam logic [4:0] S_FFIN = 5'd20;
  localparam logic [4:0] S_OUT  = 5'd21;
  localparam logic [4:0] S_FDV  = 5'd22;

  logic [4:0] state_q, state_d, cnt_q, cnt_d;
  logic [9:0] smin_q, smax_q, tol_q;
  logic [11:0] cap_q;
  logic [13:0] slow_q, look_q;
  logic [1:0] warn_q, warn_d;

  logic signed [15:0] x_q, y_q, h_q, x_d, y_d, h_d;
  logic ok_q, ok_d;
  logic [2:0] mode_q, mode_d;
  logic [1:0] zone_q, zone_d;

  logic signed [53:0] prod_q, prod_d, acc_q, acc_d;
  logic signed [32:0] ma;
  logic signed [20:0] mb;
  logic mul_en;
  logic [31:0] d2_q, d2_d;
  logic [27:0] ss_q, ss_d;

  logic [47:0] rad_q, rad_d;
  logic [26:0] rem_q, rem_d, rem_n, trial;
  logic [23:0] root_q, root_d;
  logic sq_ctx_q, sq_ctx_d;

  logic [23:0] dvd_q, dvd_d;
  logic [13:0] drem_q, drem_d, dvs_q, dvs_d;
  logic [14:0] drn;
  logic neg_q, neg_d;

  logic [9:0] vel_q, vel_d;
  logic signed [35:0] cx_q, cx_d, cy_q, cy_d, sx, sy;
  logic signed [20:0] cz_q, cz_d, zr, at;
  logic [14:0] f_q, f_d;
  logic [1:0] dir_q, dir_d;

  logic signed [LINW-1:0] rlin_q, rlin_d;
  logic signed [TURNW-1:0] rturn_q, rturn_d;
  logic [STW-1:0] rst_q, rst_d;

  logic out_valid_q, out_valid_d;
  logic signed [LINW-1:0] olin_q;
  logic signed [TURNW-1:0] oturn_q;
  logic [STW-1:0] ost_q;
  logic [1:0] owarn_q;
  logic out_load;

  logic signed [16:0] hx, yx, xx;
  logic [16:0] ah, ay, ax;
  logic signed [18:0] fs, hs, ahs, e_far, pis;
  logic [1:0] dir_far;
  logic signed [39:0] nsum;
  logic signed [24:0] np;
  logic signed [25:0] rq, rcap, tnear, tfar;
  logic moving, obstacle, in_slow;

  assign hx  = {h_q[15], h_q};
  assign yx  = {y_q[15], y_q};
  assign xx  = {x_q[15], x_q};
  assign ah  = hx[16] ? 17'(-hx) : 17'(hx);
  assign ay  = yx[16] ? 17'(-yx) : 17'(yx);
  assign ax  = xx[16] ? 17'(-xx) : 17'(xx);
  assign pis = 19'sd25736;
  assign fs  = $signed({4'b0, f_q});
  assign hs  = {{3{h_q[15]}}, h_q};
  assign ahs = $signed({2'b0, ah});

  // sqrt, divide and CORDIC step logic
  assign rem_n = {rem_q[24:0], rad_q[47:46]};
  assign trial = {1'b0, root_q, 2'b01};
  assign drn   = {drem_q, dvd_q[23]};
  assign sx    = cx_q >>> cnt_q;
  assign sy    = cy_q >>> cnt_q;
  assign at    = $signed({4'b0, atan_q16(cnt_q)});
  assign zr    = (cz_q + 21'sd4) >>> 3;

  assign moving   = ({8'b0, root_q[15:0]} >= {14'b0, tol_q}) &&
                    (xx < $signed({7'b0, tol_q}));
  assign obstacle = (zone_q == 2'd1 && mode_q == ModeRun3) ||
                    (zone_q != 2'd0 && mode_q == ModeRun1);
  assign in_slow  = (slow_q != 14'd0) && ({1'b0, d2_q} <= {5'b0, ss_q});

  // far-field heading error and turn direction
  always_comb begin
    e_far = '0;
    dir_far = DirNone;
    if (!y_q[15] && y_q != 16'sd0 && !h_q[15] && h_q != 16'sd0) begin
      if (hs > fs) begin e_far = pis - fs - ahs; dir_far = DirLeft; end
      else begin e_far = fs + ahs - pis; dir_far = DirRight; end
    end else if (!y_q[15] && y_q != 16'sd0 && h_q[15]) begin
      e_far = pis + fs - ahs; dir_far = DirRight;
    end else if (y_q[15] && h_q[15]) begin
      if (ahs > fs) begin e_far = pis - fs - ahs; dir_far = DirRight; end
      else begin e_far = fs + ahs - pis; dir_far = DirLeft; end
    end else if (y_q[15] && !h_q[15] && h_q != 16'sd0) begin
      e_far = pis + fs - ahs; dir_far = DirLeft;
    end
  end

  assign nsum = 40'(acc_q) + 40'(prod_q) + 40'sd409600;
  assign np   = nsum[39:15];

  always_comb begin
    // far field: quotient by 25 sits in the reciprocal product from bit 25 upward
    rq = neg_q ? -$signed({2'b0, prod_q[48:25]}) : $signed({2'b0, prod_q[48:25]});
    if (state_q == S_NFIN) rq = 26'((prod_q + 54'sd4096) >>> 13);
    rcap = (rq >= $signed({14'b0, cap_q})) ? $signed({14'b0, cap_q}) : rq;
    tnear = (h_q > 16'sd0) ? rcap : -rcap;
    case (dir_q)
      DirLeft:  tfar = rcap;
      DirRight: tfar = -rcap;
      default:  tfar = '0;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    mul_en = 1'b1;
    unique case (state_q)
      S_MXX:  begin ma = 33'(x_q); mb = 21'(x_q); end
      S_MYY:  begin ma = 33'(y_q); mb = 21'(y_q); end
      S_MSS:  begin ma = $signed({19'b0, slow_q}); mb = $signed({7'b0, slow_q}); end
      S_CHK:  begin ma = $signed({23'b0, smax_q}); mb = $signed({11'b0, smax_q}); end
      S_MV:   begin ma = $signed({1'b0, d2_q}); mb = $signed({1'b0, prod_q[19:0]}); end
      S_TURN: begin ma = 33'(pis - ahs); mb = 21'sd250; end
      S_FE:   begin ma = 33'(e_far); mb = 21'sd55000; end
      S_FM2:  begin ma = $signed({16'b0, ay}); mb = 21'sd368640; end
      S_FDV:  begin ma = 33'(FarRecip); mb = $signed({1'b0, dvd_q[19:0]}); end
      default: mul_en = 1'b0;
    endcase
  end

  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; warn_d = warn_q;
    x_d = x_q; y_d = y_q; h_d = h_q; ok_d = ok_q; mode_d = mode_q; zone_d = zone_q;
    prod_d = mul_en ? 54'(ma) * 54'(mb) : prod_q;
    acc_d = acc_q; d2_d = d2_q; ss_d = ss_q;
    rad_d = rad_q; rem_d = rem_q; root_d = root_q; sq_ctx_d = sq_ctx_q;
    dvd_d = dvd_q; drem_d = drem_q; dvs_d = dvs_q; neg_d = neg_q;
    vel_d = vel_q; cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; f_d = f_q; dir_d = dir_q;
    rlin_d = rlin_q; rturn_d = rturn_q; rst_d = rst_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d = offset_x_i; y_d = offset_y_i; h_d = heading_i;
          ok_d = pose_ok_i; mode_d = run_mode_i; zone_d = rear_zone_i;
          state_d = S_MXX;
        end
      end
      S_MXX: state_d = S_MYY;
      S_MYY: begin
        acc_d = prod_q;
        state_d = S_MSS;
      end
      S_MSS: begin
        d2_d = acc_q[31:0] + prod_q[31:0];
        state_d = S_SQI;
      end
      S_SQI: begin
        ss_d = prod_q[27:0];
        rad_d = {16'b0, d2_q};
        rem_d = '0; root_d = '0; cnt_d = '0; sq_ctx_d = 1'b0;
        rlin_d = '0; rturn_d = '0; rst_d = StatRun;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (rem_n >= trial) begin
          rem_d = rem_n - trial; root_d = {root_q[22:0], 1'b1};
        end else begin
          rem_d = rem_n; root_d = {root_q[22:0], 1'b0};
        end
        rad_d = {rad_q[45:0], 2'b00};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(SqrtSteps - 1)) state_d = sq_ctx_q ? S_DIVI : S_CHK;
      end
      S_CHK: begin
        state_d = S_OUT;
        if (!ok_q) begin
          warn_d = WarnPoseErr; rst_d = StatPoseErr;
        end else if (mode_q >= ModeRun1 && mode_q <= ModeRun3) begin
          if (!moving) rst_d = StatArrived;
          else if (obstacle) warn_d = WarnObstacle;
          else begin
            warn_d = WarnNone;
            if (in_slow) state_d = S_MV;
            else begin vel_d = smax_q; state_d = S_TURN; end
          end
        end else if (mode_q == ModeReset) begin
          warn_d = WarnNone;
        end
      end
      S_MV: state_d = S_SQI2;
      S_SQI2: begin
        rad_d = prod_q[47:0];
        rem_d = '0; root_d = '0; cnt_d = '0; sq_ctx_d = 1'b1;
        state_d = S_SQRT;
      end
      S_DIVI: begin
        dvd_d = root_q; dvs_d = slow_q; drem_d = '0; cnt_d = '0;
        neg_d = 1'b0;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (drn >= {1'b0, dvs_q}) begin
          drem_d = 14'(drn - {1'b0, dvs_q}); dvd_d = {dvd_q[22:0], 1'b1};
        end else begin
          drem_d = drn[13:0]; dvd_d = {dvd_q[22:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(SqrtSteps - 1)) state_d = S_VEL;
      end
      S_VEL: begin
        // clamp to max first, then min wins
        vel_d = (dvd_q >= {14'b0, smax_q}) ? smax_q : dvd_q[9:0];
        if (vel_d <= smin_q) vel_d = smin_q;
        state_d = S_TURN;
      end
      S_TURN: begin
        rlin_d = (vel_q > 10'(SpeedLim)) ? -11'sd1000 : -$signed({1'b0, vel_q});
        state_d = (ax <= {3'b0, slow_q}) ? S_NFIN : S_CORI;
      end
      S_NFIN: begin
        rturn_d = sat_turn(tnear);
        state_d = S_OUT;
      end
      S_CORI: begin
        cx_d = $signed({6'b0, look_q, 16'b0});
        cy_d = $signed({3'b0, ay, 16'b0});
        cz_d = '0; cnt_d = '0;
        if (ay == 17'd0) begin f_d = '0; state_d = S_FE; end
        else if (look_q == 14'd0) begin f_d = 15'(HalfPiQ13); state_d = S_FE; end
        else state_d = S_COR;
      end
      S_COR: begin
        if (!cy_q[35]) begin
          cx_d = cx_q + sy; cy_d = cy_q - sx; cz_d = cz_q + at;
        end else begin
          cx_d = cx_q - sy; cy_d = cy_q + sx; cz_d = cz_q - at;
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(CordSteps - 1)) state_d = S_CORF;
      end
      S_CORF: begin
        f_d = zr[20] ? 15'd0 : zr[14:0];
        state_d = S_FE;
      end
      S_FE: begin
        dir_d = dir_far;
        state_d = S_FM2;
      end
      S_FM2: begin
        acc_d = prod_q;
        state_d = S_FM3;
      end
      S_FM3: begin
        // floor divide by 819200: shift by 2^15, then divide by 25 by reciprocal
        if (np[24]) begin
          dvd_d = 24'(-np + 25'sd24); neg_d = 1'b1;
        end else begin
          dvd_d = np[23:0]; neg_d = 1'b0;
        end
        state_d = S_FDV;
      end
      S_FDV: state_d = S_FFIN;
      S_FFIN: begin
        rturn_d = sat_turn(tfar);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      warn_q <= WarnNone;
      out_valid_q <= 1'b0;
      sq_ctx_q <= 1'b0;
      smin_q <= 10'd40;
      smax_q <= 10'd70;
      cap_q <= 12'd150;
      slow_q <= 14'd600;
      look_q <= 14'd400;
      tol_q <= 10'd0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      warn_q <= warn_d;
      out_valid_q <= out_valid_d;
      sq_ctx_q <= sq_ctx_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgSpeedMin: smin_q <= cfg_wdata_i[9:0];
          CfgSpeedMax: smax_q <= cfg_wdata_i[9:0];
          CfgTurnCap:  cap_q  <= cfg_wdata_i[11:0];
          CfgSlowZone: slow_q <= cfg_wdata_i;
          CfgLookAhd:  look_q <= cfg_wdata_i;
          CfgArrivTol: tol_q  <= cfg_wdata_i[9:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; h_q <= h_d; ok_q <= ok_d; mode_q <= mode_d; zone_q <= zone_d;
    prod_q <= prod_d; acc_q <= acc_d; d2_q <= d2_d; ss_q <= ss_d;
    rad_q <= rad_d; rem_q <= rem_d; root_q <= root_d;
    dvd_q <= dvd_d; drem_q <= drem_d; dvs_q <= dvs_d; neg_q <= neg_d;
    vel_q <= vel_d; cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d; f_q <= f_d; dir_q <= dir_d;
    rlin_q <= rlin_d; rturn_q <= rturn_d; rst_q <= rst_d;
    if (out_load) begin
      olin_q <= rlin_q; oturn_q <= rturn_q; ost_q <= rst_q; owarn_q <= warn_q;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign linear_speed_o = olin_q;
  assign turn_rate_o    = oturn_q;
  assign step_status_o  = ost_q;
  assign warning_o      = owarn_q;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the reverse docking steering block.
module testbench;
  import rds_pkg::*;

  localparam logic [MODEW-1:0] ModeRun2 = 3'd2;
  localparam logic [MODEW-1:0] ModeHold = 3'd4;
  localparam longint FarDen = 819200;
  localparam int CycleLimit = 1000000;
  localparam int HoldCycles = 600;
  localparam int DrainCycles = 200;

  typedef struct {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] hdg;
    logic                 ok;
    logic [MODEW-1:0]     mode;
    logic [ZONEW-1:0]     zone;
  } pose_word_t;

  typedef struct {
    logic signed [LINW-1:0]  lin;
    logic signed [TURNW-1:0] turn;
    logic [STW-1:0]          st;
    logic [1:0]              warn;
  } steer_cmd_t;

  class steer_scoreboard;
    longint spd_min, spd_max, turn_cap, slow_zone, look_ahd, arriv_tol;
    logic [1:0] warn_hold;
    steer_cmd_t cmd_q[$];
    int errors, n_in, n_out;

    function new();
      spd_min = 40; spd_max = 70; turn_cap = 150;
      slow_zone = 600; look_ahd = 400; arriv_tol = 0;
      warn_hold = WarnNone;
      errors = 0; n_in = 0; n_out = 0;
    endfunction

    function void set_reg(logic [CIDXW-1:0] idx, logic [CDATW-1:0] val);
      case (idx)
        CfgSpeedMin: spd_min   = val[9:0];
        CfgSpeedMax: spd_max   = val[9:0];
        CfgTurnCap:  turn_cap  = val[11:0];
        CfgSlowZone: slow_zone = val[13:0];
        CfgLookAhd:  look_ahd  = val[13:0];
        CfgArrivTol: arriv_tol = val[9:0];
        default: ;
      endcase
    endfunction

    function longint sqrt_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function longint div_floor(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    // atan(ay / lx) in Q13 via 17-step vectoring CORDIC in Q16
    function longint follow_angle(longint ay, longint lx);
      longint cx, cy, z, nx;
      int unsigned atab [17];
      atab = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
               256, 128, 64, 32, 16, 8, 4, 2, 1};
      if (ay == 0) return 0;
      if (lx == 0) return HalfPiQ13;
      cx = lx * 65536;
      cy = ay * 65536;
      z = 0;
      for (int i = 0; i < 17; i++) begin
        if (cy >= 0) begin
          nx = cx + (cy >>> i); cy = cy - (cx >>> i); z += atab[i];
        end else begin
          nx = cx - (cy >>> i); cy = cy + (cx >>> i); z -= atab[i];
        end
        cx = nx;
      end
      z = (z + 4) >>> 3;
      return z < 0 ? 0 : z;
    endfunction

    function steer_cmd_t steer_for(pose_word_t w);
      longint x, y, h, ah, ay, ax, d2, d, vel, r, f, e, lin, turn;
      logic [1:0] dir;
      steer_cmd_t c;
      x = w.x; y = w.y; h = w.hdg;
      lin = 0; turn = 0;
      c.st = StatRun;
      if (!w.ok) begin
        warn_hold = WarnPoseErr;
        c.st = StatPoseErr;
      end else if (w.mode >= ModeRun1 && w.mode <= ModeRun3) begin
        d2 = x * x + y * y;
        d = sqrt_floor(d2);
        if (!(d >= arriv_tol && x < arriv_tol)) begin
          c.st = StatArrived;
        end else if ((w.zone == 1 && w.mode == ModeRun3) ||
                     (w.zone != 0 && w.mode == ModeRun1)) begin
          warn_hold = WarnObstacle;
        end else begin
          warn_hold = WarnNone;
          ah = h < 0 ? -h : h;
          ay = y < 0 ? -y : y;
          ax = x < 0 ? -x : x;
          if (slow_zone > 0 && d2 <= slow_zone * slow_zone) begin
            vel = sqrt_floor(spd_max * spd_max * d2) / slow_zone;
            if (vel >= spd_max) vel = spd_max;
            if (vel <= spd_min) vel = spd_min;
          end else begin
            vel = spd_max;
          end
          lin = -vel;
          if (ax <= slow_zone) begin
            r = ((PiQ13 - ah) * KNear + 4096) >>> 13;
            if (r >= turn_cap) r = turn_cap;
            turn = h > 0 ? r : -r;
          end else begin
            f = follow_angle(ay, look_ahd);
            e = 0;
            dir = DirNone;
            if (y > 0 && h > 0) begin
              if (h > f) begin e = PiQ13 - f - ah; dir = DirLeft; end
              else begin e = f + ah - PiQ13; dir = DirRight; end
            end else if (y > 0 && h < 0) begin
              e = PiQ13 + f - ah; dir = DirRight;
            end else if (y < 0 && h < 0) begin
              if (ah > f) begin e = PiQ13 - f - ah; dir = DirRight; end
              else begin e = f + ah - PiQ13; dir = DirLeft; end
            end else if (y < 0 && h > 0) begin
              e = PiQ13 + f - ah; dir = DirLeft;
            end
            r = div_floor(e * KHead + ay * KLat + FarBias, FarDen);
            if (r >= turn_cap) r = turn_cap;
            turn = dir == DirLeft ? r : (dir == DirRight ? -r : 0);
          end
        end
      end else if (w.mode == ModeReset) begin
        warn_hold = WarnNone;
      end
      if (lin < -SpeedLim) lin = -SpeedLim;
      if (turn > TurnLimit) turn = TurnLimit;
      if (turn < -TurnLimit) turn = -TurnLimit;
      c.lin = lin[LINW-1:0];
      c.turn = turn[TURNW-1:0];
      c.warn = warn_hold;
      return c;
    endfunction

    function void note_pose(pose_word_t w);
      cmd_q.push_back(steer_for(w));
      n_in++;
    endfunction

    function void check_result(steer_cmd_t got);
      steer_cmd_t exp_c;
      n_out++;
      if (cmd_q.size() == 0) begin
        $error("result with no pending command");
        errors++;
        return;
      end
      exp_c = cmd_q.pop_front();
      if (got.lin !== exp_c.lin) begin
        $error("linear_speed: expected %0d, actual %0d", exp_c.lin, got.lin);
        errors++;
      end
      if (got.turn !== exp_c.turn) begin
        $error("turn_rate: expected %0d, actual %0d", exp_c.turn, got.turn);
        errors++;
      end
      if (got.st !== exp_c.st) begin
        $error("step_status: expected %0d, actual %0d", exp_c.st, got.st);
        errors++;
      end
      if (got.warn !== exp_c.warn) begin
        $error("warning: expected %0d, actual %0d", exp_c.warn, got.warn);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CIDXW-1:0] cfg_idx_i = '0;
  logic [CDATW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [XW-1:0] offset_x_i = '0, offset_y_i = '0, heading_i = '0;
  logic pose_ok_i = 1'b0;
  logic [MODEW-1:0] run_mode_i = '0;
  logic [ZONEW-1:0] rear_zone_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [LINW-1:0] linear_speed_o;
  logic signed [TURNW-1:0] turn_rate_o;
  logic [STW-1:0] step_status_o;
  logic [1:0] warning_o;

  steer_scoreboard sb = new();
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int cycles = 0;

  reverse_docking_steer u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: check accepted words, then choose next stall value
  initial begin
    int held;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result('{linear_speed_o, turn_rate_o, step_status_o, warning_o});
      if (hold_req && held < HoldCycles) begin
        held++;
        out_stall_i <= 1'b1;
      end else begin
        if (held >= HoldCycles) hold_req = 1'b0;
        out_stall_i <= !no_idle && ($urandom_range(99) < 37);
      end
    end
  end

  task automatic drive_pose(pose_word_t w);
    while (!no_idle && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    offset_x_i  <= w.x;
    offset_y_i  <= w.y;
    heading_i   <= w.hdg;
    pose_ok_i   <= w.ok;
    run_mode_i  <= w.mode;
    rear_zone_i <= w.zone;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sb.note_pose(w);
  endtask

  task automatic write_reg(logic [CIDXW-1:0] idx, logic [CDATW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // wait for every command to come out, then let the sequencer settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.cmd_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_regs(int smin, int smax, int cap, int slow, int look, int tol);
    write_reg(CfgSpeedMin, CDATW'(smin));
    write_reg(CfgSpeedMax, CDATW'(smax));
    write_reg(CfgTurnCap, CDATW'(cap));
    write_reg(CfgSlowZone, CDATW'(slow));
    write_reg(CfgLookAhd, CDATW'(look));
    write_reg(CfgArrivTol, CDATW'(tol));
  endtask

  function automatic logic signed [XW-1:0] pick_offset(bit back);
    int k;
    k = $urandom_range(99);
    if (k < 40) return XW'($urandom_range(1400) - 700);
    if (k < 80)
      return back ? XW'(-$urandom_range(12000)) : XW'($urandom_range(12000) - 6000);
    return XW'($urandom());
  endfunction

  function automatic pose_word_t rand_pose();
    pose_word_t w;
    w.x = pick_offset(1'b1);
    w.y = pick_offset(1'b0);
    w.hdg = ($urandom_range(99) < 5) ? 16'sd0 : XW'($urandom_range(2 * PiQ13) - PiQ13);
    w.ok = $urandom_range(99) >= 5;
    w.mode = ($urandom_range(99) < 85) ? MODEW'($urandom_range(3, 1))
                                       : MODEW'($urandom_range(7));
    w.zone = ($urandom_range(99) < 70) ? 2'd0 : ZONEW'($urandom_range(3));
    return w;
  endfunction

  task automatic run_random(int n);
    repeat (n) drive_pose(rand_pose());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words with reset register values
    drive_pose('{16'sh8000, 16'sd0, 16'sd0, 1'b1, ModeRun1, 2'd0});
    drive_pose('{16'sd32767, 16'sd32767, 16'sd25736, 1'b1, ModeRun2, 2'd0});
    drive_pose('{16'sh8000, 16'sh8000, -16'sd25736, 1'b1, ModeRun3, 2'd0});
    drive_pose('{-16'sd300, 16'sd100, 16'sd0, 1'b1, ModeRun2, 2'd0});
    drive_pose('{-16'sd300, 16'sd100, -16'sd4000, 1'b1, ModeRun2, 2'd0});
    drive_pose('{-16'sd200, -16'sd50, 16'sd9000, 1'b1, ModeRun3, 2'd2});
    drive_pose('{-16'sd5000, 16'sd0, 16'sd3000, 1'b1, ModeRun2, 2'd0});
    drive_pose('{-16'sd5000, 16'sd700, 16'sd0, 1'b1, ModeRun2, 2'd0});
    drive_pose('{-16'sd5000, 16'sd700, 16'sd20000, 1'b1, ModeRun2, 2'd0});
    drive_pose('{-16'sd5000, 16'sd700, 16'sd100, 1'b1, ModeRun2, 2'd0});
    drive_pose('{-16'sd5000, 16'sd700, -16'sd9000, 1'b1, ModeRun2, 2'd0});
    drive_pose('{-16'sd5000, -16'sd700, -16'sd20000, 1'b1, ModeRun2, 2'd0});
    drive_pose('{-16'sd5000, -16'sd700, -16'sd100, 1'b1, ModeRun2, 2'd0});
    drive_pose('{-16'sd5000, -16'sd700, 16'sd9000, 1'b1, ModeRun2, 2'd0});
    drive_pose('{-16'sd800, 16'sd10, 16'sd500, 1'b1, ModeRun1, 2'd3});
    drive_pose('{-16'sd800, 16'sd10, 16'sd500, 1'b1, ModeRun3, 2'd1});
    drive_pose('{16'sd0, 16'sd0, 16'sd500, 1'b1, ModeRun1, 2'd0});
    drive_pose('{16'sd500, 16'sd10, 16'sd500, 1'b1, ModeRun2, 2'd0});
    drive_pose('{-16'sd800, 16'sd10, 16'sd500, 1'b0, ModeRun2, 2'd0});
    drive_pose('{-16'sd800, 16'sd10, 16'sd500, 1'b1, ModeHold, 2'd0});
    drive_pose('{-16'sd800, 16'sd10, 16'sd500, 1'b1, 3'd7, 2'd3});
    drive_pose('{-16'sd800, 16'sd10, 16'sd500, 1'b1, ModeReset, 2'd0});
    drive_pose('{-16'sd800, 16'sd10, 16'sd500, 1'b1, 3'd5, 2'd0});
    drive_pose('{-16'sd800, 16'sd10, 16'sd500, 1'b1, 3'd6, 2'd0});
    run_random(230);
    drain();

    // large speed, cap, zone and tolerance values with a zero minimum speed, no idling on either side
    load_regs(0, 1000, 3000, 10000, 10000, 1000);
    no_idle = 1'b1;
    run_random(210);
    no_idle = 1'b0;
    drain();

    // full register widths, zero slow zone and lookahead; long receiver hold-off
    load_regs(1023, 1023, 4095, 0, 0, 0);
    hold_req = 1'b1;
    run_random(200);
    drain();

    load_regs(20, 300, 800, 1, 1, 5);
    run_random(200);
    drain();

    load_regs(100, 500, 1200, 16383, 16383, 1023);
    run_random(190);
    drain();

    $display("sent %0d pose words over five register settings, checked %0d commands",
             sb.n_in, sb.n_out);
    $display("%0d mismatches, %0d commands never returned", sb.errors, sb.cmd_q.size());
    if (sb.errors == 0 && sb.cmd_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rds_pkg.sv
hdl/reverse_docking_steer.sv
tb/testbench.sv
